// ----- hdl/cqs_pkg.sv -----
`default_nettype none
package cqs_pkg;

   localparam int unsigned DEPTH   = 32;
   localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned SLOT_W  = 5;
   localparam int unsigned MAXRES  = 32;

   typedef enum logic [1:0] {
      CMD_INSERT   = 2'd0,
      CMD_DELETE   = 2'd1,
      CMD_TRAVERSE = 2'd2,
      CMD_SEARCH   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_MISS  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK
   } state_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [WORD_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [WORD_W-1:0]  data;
      logic [SLOT_W-1:0]  slot;
      logic               last;
      logic               is_empty;
      logic               is_full;
   } result_type;

   typedef struct packed {
      logic               wr_en;
      logic [PTR_W-1:0]   wr_addr;
      logic [WORD_W-1:0]  wr_data;
      logic               rd_en;
      logic [PTR_W-1:0]   rd_addr;
   } ram_cmd_type;

   // Wrap at the last slot rather than at a power of two.
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/circular_queue_with_search.sv -----
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_cmd, req_value
// rsp_      out        rsp_valid / rsp_ready  rsp_status, rsp_data_out, rsp_slot_index,
//                                             rsp_last, rsp_is_empty, rsp_is_full
//
// One command at a time: req_ready is high only while the sequencer is idle.
// Insert and delete each return one result; traverse returns the N stored words
// (N capped at 32), search reads until a hit or the last stored word, one RAM read per word
// through the single read port of the slot RAM. Each result waits in the
// output register; a low rsp_ready holds the walk until the register frees.
// Synchronous active-high reset clears pointers and occupancy; slot contents
// are not cleared, no clearing pass is needed.
`default_nettype none
module circular_queue_with_search (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_cmd,
   input  wire logic signed [31:0]  req_value,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [1:0]               rsp_status,
   output logic signed [31:0]       rsp_data_out,
   output logic [4:0]               rsp_slot_index,
   output logic                     rsp_last,
   output logic                     rsp_is_empty,
   output logic                     rsp_is_full
);

   cqs_pkg::req_type              req;
   cqs_pkg::result_type           res;
   cqs_pkg::ram_cmd_type          ram_cmd;
   logic [cqs_pkg::WORD_W-1:0]    ram_rd_data;
   logic                          res_valid;
   logic                          out_free;

   // Output register: parts the sequencer from the consumer.
   logic                          rsp_valid_ff, rsp_valid_in;
   cqs_pkg::result_type           rsp_ff, rsp_in;

   assign req.cmd   = cqs_pkg::cmd_type'(req_cmd);
   assign req.value = req_value;

   // Free when empty or when the held transaction leaves this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   cqs_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req         (req),
      .res_ready   (out_free),
      .res_valid   (res_valid),
      .res         (res),
      .ram_cmd     (ram_cmd),
      .ram_rd_data (ram_rd_data)
   );

   cqs_ram #(
      .WIDTH (cqs_pkg::WORD_W),
      .DEPTH (cqs_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_cmd.wr_en),
      .wr_addr (ram_cmd.wr_addr),
      .wr_data (ram_cmd.wr_data),
      .rd_en   (ram_cmd.rd_en),
      .rd_addr (ram_cmd.rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid) begin
         // Load a new result; the sequencer only offers one when out_free.
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         // Drop the transaction that was just taken.
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_data_out   = rsp_ff.data;
   assign rsp_slot_index = rsp_ff.slot;
   assign rsp_last       = rsp_ff.last;
   assign rsp_is_empty   = rsp_ff.is_empty;
   assign rsp_is_full    = rsp_ff.is_full;

`ifndef SYNTHESIS
   a_res_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> out_free)
      else $error("result offered while output register is occupied");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new command taken while one is in progress");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_empty && rsp_is_full))
      else $error("queue reported both empty and full");

   a_full_status_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == cqs_pkg::STAT_FULL) |-> rsp_is_full)
      else $error("full status without full flag");
`endif

endmodule
`default_nettype wire

// ----- hdl/cqs_ram.sv -----
`default_nettype none
module cqs_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                  wr_data,
   input  wire logic                              rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- hdl/cqs_seq.sv -----
`default_nettype none
module cqs_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire cqs_pkg::req_type              req,
   input  wire logic                          res_ready,
   output logic                               res_valid,
   output cqs_pkg::result_type                res,
   output cqs_pkg::ram_cmd_type               ram_cmd,
   input  wire logic [cqs_pkg::WORD_W-1:0]    ram_rd_data
);

   cqs_pkg::state_type                 state_ff, state_in;
   cqs_pkg::cmd_type                   cmd_ff, cmd_in;
   logic [cqs_pkg::WORD_W-1:0]         value_ff, value_in;
   logic [cqs_pkg::PTR_W-1:0]          head_ff, head_in;
   logic [cqs_pkg::PTR_W-1:0]          tail_ff, tail_in;
   logic [cqs_pkg::CNT_W-1:0]          occ_ff, occ_in;
   logic [cqs_pkg::PTR_W-1:0]          walk_ff, walk_in;
   logic [cqs_pkg::CNT_W-1:0]          k_ff, k_in;

   logic                               is_full;
   logic                               at_end;
   logic                               trav_last;
   logic                               hit;
   logic [cqs_pkg::PTR_W-1:0]          walk_nxt;
   logic [cqs_pkg::PTR_W+cqs_pkg::SLOT_W-1:0] walk_wide;

   assign is_full   = (occ_ff == cqs_pkg::CNT_W'(cqs_pkg::DEPTH));
   assign at_end    = (k_ff == occ_ff - 1'b1);
   assign trav_last = at_end || (32'(k_ff) == 32'(cqs_pkg::MAXRES - 1));
   assign hit       = (ram_rd_data == value_ff);
   assign walk_nxt  = cqs_pkg::ptr_next(walk_ff);
   assign walk_wide = {{cqs_pkg::SLOT_W{1'b0}}, walk_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cqs_pkg::ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         occ_ff   <= occ_in;
      end
      cmd_ff   <= cmd_in;
      value_ff <= value_in;
      walk_ff  <= walk_in;
      k_ff     <= k_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      value_in  = value_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      occ_in    = occ_ff;
      walk_in   = walk_ff;
      k_in      = k_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      res       = '0;
      ram_cmd   = '0;
      ram_cmd.wr_addr = tail_ff;
      ram_cmd.wr_data = value_ff;

      case (state_ff)
         cqs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = req.cmd;
               value_in = req.value;
               state_in = cqs_pkg::ST_EXEC;
            end
         end
         cqs_pkg::ST_EXEC: begin
            if (cmd_ff == cqs_pkg::CMD_INSERT) begin
               if (res_ready) begin
                  res_valid = 1'b1;
                  res.last  = 1'b1;
                  if (is_full) begin
                     res.status = cqs_pkg::STAT_FULL;
                  end else begin
                     ram_cmd.wr_en = 1'b1;
                     tail_in       = cqs_pkg::ptr_next(tail_ff);
                     occ_in        = occ_ff + 1'b1;
                  end
                  state_in = cqs_pkg::ST_IDLE;
               end
            end else if (occ_ff == '0) begin
               if (res_ready) begin
                  res_valid  = 1'b1;
                  res.status = cqs_pkg::STAT_EMPTY;
                  res.last   = 1'b1;
                  state_in   = cqs_pkg::ST_IDLE;
               end
            end else begin
               ram_cmd.rd_en   = 1'b1;
               ram_cmd.rd_addr = head_ff;
               walk_in         = head_ff;
               k_in            = '0;
               state_in        = cqs_pkg::ST_WALK;
            end
         end
         cqs_pkg::ST_WALK: begin
            case (cmd_ff)
               cqs_pkg::CMD_DELETE: begin
                  if (res_ready) begin
                     res_valid = 1'b1;
                     res.data  = ram_rd_data;
                     res.last  = 1'b1;
                     occ_in    = occ_ff - 1'b1;
                     if (occ_ff == cqs_pkg::CNT_W'(1)) begin
                        head_in = '0;
                        tail_in = '0;
                     end else begin
                        head_in = cqs_pkg::ptr_next(head_ff);
                     end
                     state_in = cqs_pkg::ST_IDLE;
                  end
               end
               cqs_pkg::CMD_TRAVERSE: begin
                  if (res_ready) begin
                     res_valid = 1'b1;
                     res.data  = ram_rd_data;
                     res.slot  = walk_wide[cqs_pkg::SLOT_W-1:0];
                     res.last  = trav_last;
                     if (trav_last) begin
                        state_in = cqs_pkg::ST_IDLE;
                     end else begin
                        walk_in         = walk_nxt;
                        k_in            = k_ff + 1'b1;
                        ram_cmd.rd_en   = 1'b1;
                        ram_cmd.rd_addr = walk_nxt;
                     end
                  end
               end
               cqs_pkg::CMD_SEARCH: begin
                  if (hit) begin
                     if (res_ready) begin
                        res_valid = 1'b1;
                        res.data  = ram_rd_data;
                        res.slot  = walk_wide[cqs_pkg::SLOT_W-1:0];
                        res.last  = 1'b1;
                        state_in  = cqs_pkg::ST_IDLE;
                     end
                  end else if (at_end) begin
                     if (res_ready) begin
                        res_valid  = 1'b1;
                        res.status = cqs_pkg::STAT_MISS;
                        res.last   = 1'b1;
                        state_in   = cqs_pkg::ST_IDLE;
                     end
                  end else begin
                     walk_in         = walk_nxt;
                     k_in            = k_ff + 1'b1;
                     ram_cmd.rd_en   = 1'b1;
                     ram_cmd.rd_addr = walk_nxt;
                  end
               end
               default: begin
                  state_in = cqs_pkg::ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = cqs_pkg::ST_IDLE;
         end
      endcase

      // Flags reflect the queue after this step.
      res.is_empty = (occ_in == '0);
      res.is_full  = (occ_in == cqs_pkg::CNT_W'(cqs_pkg::DEPTH));
   end

endmodule
`default_nettype wire
